@@ hdl/assert_macros.svh @@
// Assertion helpers used by the checker file kfli_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/kfli_pkg.sv @@
`default_nettype none
package kfli_pkg;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] OUT_SINGLE = 2'd0;
    localparam logic [1:0] OUT_BEFORE = 2'd1;
    localparam logic [1:0] OUT_INTERP = 2'd2;
    localparam logic [1:0] OUT_CLAMP  = 2'd3;

    typedef struct packed {
        logic               command;
        logic        [5:0]  key_slot;
        logic        [31:0] key_time;
        logic signed [31:0] key_value_x;
        logic signed [31:0] key_value_y;
        logic signed [31:0] key_value_z;
        logic        [31:0] query_time;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result_x;
        logic signed [31:0] result_y;
        logic signed [31:0] result_z;
        logic        [5:0]  segment_start;
        logic        [1:0]  outcome;
    } t_out_item;

endpackage
`default_nettype wire

@@ hdl/kfli_front.sv @@
`default_nettype none
// Front: accepts commands into a short queue; the back pops them.
module kfli_front
    import kfli_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_in_item i_item,
    output logic          o_full,
    input  wire logic     i_pop,
    output logic          o_valid,
    output t_in_item      o_item
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_in_item          r_mem [DEPTH];
    logic [AW-1:0]     r_wp, r_rp;
    logic [AW:0]       r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop && o_valid) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push && !o_full) - (AW+1)'(i_pop && o_valid);
        end
    end
endmodule
`default_nettype wire

@@ hdl/kfli_back.sv @@
`default_nettype none
// Back: key memory, linear segment search, restoring divider, lerp.
module kfli_back
    import kfli_pkg::*;
#(
    parameter int MAX_KEYS    = 64,
    parameter int FACTOR_BITS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [6:0] i_keys_in_use,
    input  wire logic       i_valid,
    input  wire t_in_item   i_item,
    output logic            o_pop,
    output logic            o_strobe,
    output t_out_item       o_result
);
    localparam int KW = $clog2(MAX_KEYS);
    localparam int DW = 32 + FACTOR_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_CMP, S_RD_T1, S_T1, S_DIV, S_MUL, S_ADD, S_RD_LAST, S_LAST
    } t_state;

    logic [31:0]  r_tmem [MAX_KEYS];
    logic [95:0]  r_vmem [MAX_KEYS];
    logic [31:0]  r_tq;
    logic [95:0]  r_vq;
    logic [KW-1:0] r_ra;

    t_state        r_st;
    logic [31:0]   r_q;
    logic [KW:0]   r_n;
    logic [KW-1:0] r_i;
    logic [31:0]   r_t2;
    logic [31:0]   r_span;
    logic [DW-1:0] r_rem;
    logic [FACTOR_BITS-1:0] r_fac;
    logic [5:0]    r_div_cnt;
    logic [1:0]    r_c;
    logic [95:0]   r_v1, r_v2;
    logic signed [32+FACTOR_BITS+1:0] r_prod;
    logic          r_strobe;
    t_out_item     r_res;

    logic [KW:0]   w_n;
    logic [KW:0]   w_kiu;
    logic          w_wr;
    logic          w_last;
    logic [KW-1:0] n_ra;
    logic [DW:0]   w_trial;
    logic signed [32:0] w_d;
    logic signed [31:0] w_s;
    logic signed [31:0] w_sum;

    assign o_strobe = r_strobe;
    assign o_result = r_res;
    assign o_pop    = (r_st == S_IDLE) && i_valid;
    assign w_wr     = o_pop && (i_item.command == CMD_LOAD)
                      && ({26'd0, i_item.key_slot} < 32'(MAX_KEYS));
    // key r_i+1 is the last key
    assign w_last   = ((KW+1)'(r_i) + (KW+1)'(2)) >= r_n;

    always_comb begin
        w_kiu = (KW+1)'(i_keys_in_use);
        if (32'(i_keys_in_use) > 32'(MAX_KEYS)) w_n = (KW+1)'(MAX_KEYS);
        else if (i_keys_in_use == 7'd0) w_n = (KW+1)'(1);
        else w_n = w_kiu;
    end

    always_comb begin
        unique case (r_c)
            2'd0:    w_s = r_v1[95:64];
            2'd1:    w_s = r_v1[63:32];
            default: w_s = r_v1[31:0];
        endcase
        unique case (r_c)
            2'd0:    w_d = 33'(signed'(r_v2[95:64])) - 33'(w_s);
            2'd1:    w_d = 33'(signed'(r_v2[63:32])) - 33'(w_s);
            default: w_d = 33'(signed'(r_v2[31:0])) - 33'(w_s);
        endcase
        w_sum = w_s + 32'(r_prod >>> FACTOR_BITS);
        w_trial = {r_rem, 1'b0} - {{(DW-31){1'b0}}, r_span};
    end

    // read address: next memory index per state, held otherwise
    always_comb begin
        n_ra = r_ra;
        if (o_pop) n_ra = (w_n == (KW+1)'(1)) ? '0 : KW'(1);
        else if (r_st == S_RD) begin
            if (r_q < r_tq) n_ra = r_i;
            else if (w_last) n_ra = r_i + 1'b1;
            else n_ra = r_i + 1'b1 + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_tmem[KW'(i_item.key_slot)] <= i_item.key_time;
            r_vmem[KW'(i_item.key_slot)] <= {i_item.key_value_x, i_item.key_value_y,
                                             i_item.key_value_z};
        end
        r_tq <= r_tmem[n_ra];
        r_vq <= r_vmem[n_ra];
        r_ra <= n_ra;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (o_pop && i_item.command == CMD_QUERY) begin
                        r_q <= i_item.query_time;
                        r_n <= w_n;
                        r_i <= '0;
                        r_st <= (w_n == (KW+1)'(1)) ? S_RD_LAST : S_RD;
                    end
                end
                S_RD: begin
                    // r_tq holds time of key r_i+1
                    r_t2 <= r_tq;
                    r_v2 <= r_vq;
                    if (r_q < r_tq) begin
                        r_st <= S_RD_T1;
                    end else if (w_last) begin
                        r_st <= S_RD_LAST;
                    end else begin
                        r_i  <= r_i + 1'b1;
                        r_st <= S_CMP;
                    end
                end
                S_CMP: r_st <= S_RD;
                S_RD_T1: r_st <= S_T1;
                S_T1: begin
                    r_v1 <= r_vq;
                    if (r_tq > r_q) begin
                        r_res <= {r_vq, 6'(r_i), OUT_BEFORE};
                        r_strobe <= 1'b1;
                        r_st <= S_IDLE;
                    end else if (r_tq == r_t2) begin
                        r_res <= {r_vq, 6'(r_i), OUT_INTERP};
                        r_strobe <= 1'b1;
                        r_st <= S_IDLE;
                    end else begin
                        r_span <= r_t2 - r_tq;
                        r_rem  <= DW'(r_q - r_tq);
                        r_fac  <= '0;
                        r_div_cnt <= '0;
                        r_st <= S_DIV;
                    end
                end
                S_DIV: begin
                    // restoring division, one quotient bit per cycle
                    if (!w_trial[DW]) begin
                        r_rem <= w_trial[DW-1:0];
                        r_fac <= {r_fac[FACTOR_BITS-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[DW-2:0], 1'b0};
                        r_fac <= {r_fac[FACTOR_BITS-2:0], 1'b0};
                    end
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (r_div_cnt == 6'(FACTOR_BITS-1)) begin
                        r_c  <= 2'd0;
                        r_st <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod <= (32+FACTOR_BITS+2)'(w_d * $signed({1'b0, r_fac}));
                    r_st <= S_ADD;
                end
                S_ADD: begin
                    unique case (r_c)
                        2'd0:    r_res.result_x <= w_sum;
                        2'd1:    r_res.result_y <= w_sum;
                        default: r_res.result_z <= w_sum;
                    endcase
                    if (r_c == 2'd2) begin
                        r_res.segment_start <= 6'(r_i);
                        r_res.outcome <= OUT_INTERP;
                        r_strobe <= 1'b1;
                        r_st <= S_IDLE;
                    end else begin
                        r_c <= r_c + 1'b1;
                        r_st <= S_MUL;
                    end
                end
                S_RD_LAST: r_st <= S_LAST;
                S_LAST: begin
                    if (r_n == (KW+1)'(1)) r_res <= {r_vq, 6'd0, OUT_SINGLE};
                    else r_res <= {r_vq, 6'(r_n - 1'b1), OUT_CLAMP};
                    r_strobe <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ hdl/keyframe_linear_interpolator_top.sv @@
`default_nettype none
// Load: table written when the back end pops the item from the queue; no result.
// Query: serial segment search, then for an interpolation a FACTOR_BITS-bit divide and
// a multiply-add per axis; bounded by the serial key scan and the bit-serial divider.
// One query in the back end at a time; a 2-entry queue accepts ahead of it.
// Synchronous active-low reset: queue empty, keys_in_use = 1, table contents undefined.
module keyframe_linear_interpolator_top
    import kfli_pkg::*;
#(
    parameter int MAX_KEYS    = 64,
    parameter int FACTOR_BITS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire t_in_item   i_item,
    input  wire logic       i_cfg_we,
    input  wire logic [6:0] i_cfg_wdata,
    output logic            o_strobe,
    output t_out_item       o_result
);
    logic [6:0] r_keys_in_use;
    logic       w_pop, w_valid;
    t_in_item   w_q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_keys_in_use <= 7'd1;
        else if (i_cfg_we) r_keys_in_use <= i_cfg_wdata;
    end

    kfli_front #(.DEPTH(2)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(start), .i_item(i_item),
        .o_full(busy), .i_pop(w_pop), .o_valid(w_valid), .o_item(w_q_item)
    );

    kfli_back #(.MAX_KEYS(MAX_KEYS), .FACTOR_BITS(FACTOR_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_keys_in_use(r_keys_in_use),
        .i_valid(w_valid), .i_item(w_q_item), .o_pop(w_pop),
        .o_strobe(o_strobe), .o_result(o_result)
    );
endmodule
`default_nettype wire

@@ hdl/kfli_checker.sv @@
`default_nettype none
`include "assert_macros.svh"
module kfli_checker
    import kfli_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      start,
    input wire logic      busy,
    input wire logic      o_strobe,
    input wire t_out_item o_result
);
    `ASSERT_IMPLIES(a_single_seg0, i_clk, i_rst_n, o_strobe && o_result.outcome == OUT_SINGLE, o_result.segment_start == 6'd0)
    `ASSERT_NEXT(a_strobe_pulse, i_clk, i_rst_n, o_strobe && !start, !o_strobe)
    // a clamp needs at least two keys, so it never names key 0
    `ASSERT_IMPLIES(a_clamp_not_first, i_clk, i_rst_n, o_strobe && o_result.outcome == OUT_CLAMP, o_result.segment_start != 6'd0)
endmodule

bind keyframe_linear_interpolator_top kfli_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_strobe(o_strobe), .o_result(o_result)
);
`default_nettype wire

@@ verif/keyframe_lerp_checker.sv @@
`default_nettype none
module keyframe_lerp_checker
    import kfli_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    input  wire logic       busy,
    input  wire t_in_item   i_item,
    input  wire logic       i_cfg_we,
    input  wire logic [6:0] i_cfg_wdata,
    input  wire logic       o_strobe,
    input  wire t_out_item  o_result,
    output int              o_errors,
    output int              o_pending,
    output int              o_queries,
    output int              o_loads,
    output int              o_outcome_seen [4]
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NKEYS = 64;
    localparam int FBITS = 16;

    logic        [31:0] key_times [NKEYS];
    logic signed [31:0] key_vecs  [NKEYS][3];
    logic        [6:0]  key_count;
    t_out_item          expected_lerps [$];

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
        o_errors++;
    endtask

    function automatic t_out_item emit_key(input int idx, input int seg, input logic [1:0] oc);
        t_out_item r;
        r.result_x      = key_vecs[idx][0];
        r.result_y      = key_vecs[idx][1];
        r.result_z      = key_vecs[idx][2];
        r.segment_start = 6'(seg);
        r.outcome       = oc;
        return r;
    endfunction

    function automatic t_out_item lerp_predict(input logic [31:0] q);
        int          n;
        int          seg;
        bit          found;
        longint      span;
        longint      off;
        longint      factor;
        longint      s;
        longint      d;
        longint      comp [3];
        t_out_item   r;
        n = key_count;
        found = 0;
        seg = 0;
        if (n == 0) n = 1;
        if (n > NKEYS) n = NKEYS;
        if (n == 1) return emit_key(0, 0, OUT_SINGLE);
        for (int i = 0; i + 1 < n; i++) begin
            if (q < key_times[i + 1]) begin
                seg = i;
                found = 1;
                break;
            end
        end
        if (!found) return emit_key(n - 1, n - 1, OUT_CLAMP);
        if (key_times[seg] > q) return emit_key(seg, seg, OUT_BEFORE);
        if (key_times[seg] == key_times[seg + 1]) return emit_key(seg, seg, OUT_INTERP);
        span   = longint'(key_times[seg + 1]) - longint'(key_times[seg]);
        off    = longint'(q) - longint'(key_times[seg]);
        factor = (off << FBITS) / span;
        for (int c = 0; c < 3; c++) begin
            s = key_vecs[seg][c];
            d = longint'(key_vecs[seg + 1][c]) - s;
            comp[c] = s + ((d * factor) >>> FBITS);  // arithmetic shift floors
        end
        r = emit_key(seg, seg, OUT_INTERP);
        r.result_x = comp[0][31:0];
        r.result_y = comp[1][31:0];
        r.result_z = comp[2][31:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            key_count = 7'd1;
            expected_lerps.delete();
            o_errors = 0;
            o_queries = 0;
            o_loads = 0;
            for (int i = 0; i < 4; i++) o_outcome_seen[i] = 0;
        end else begin
            if (o_strobe) begin
                if (expected_lerps.size() == 0) begin
                    report("unexpected result transfer", 1, 0);
                end else begin
                    want = expected_lerps.pop_front();
                    o_outcome_seen[o_result.outcome]++;
                    if (o_result.result_x !== want.result_x)
                        report("result_x", o_result.result_x, want.result_x);
                    if (o_result.result_y !== want.result_y)
                        report("result_y", o_result.result_y, want.result_y);
                    if (o_result.result_z !== want.result_z)
                        report("result_z", o_result.result_z, want.result_z);
                    if (o_result.segment_start !== want.segment_start)
                        report("segment_start", o_result.segment_start, want.segment_start);
                    if (o_result.outcome !== want.outcome)
                        report("outcome", o_result.outcome, want.outcome);
                end
            end
            if (start && !busy) begin
                if (i_item.command == CMD_LOAD) begin
                    key_times[i_item.key_slot]   = i_item.key_time;
                    key_vecs[i_item.key_slot][0] = i_item.key_value_x;
                    key_vecs[i_item.key_slot][1] = i_item.key_value_y;
                    key_vecs[i_item.key_slot][2] = i_item.key_value_z;
                    o_loads++;
                end else begin
                    expected_lerps = {expected_lerps, lerp_predict(i_item.query_time)};
                    o_queries++;
                end
            end
            if (i_cfg_we) key_count = i_cfg_wdata;
        end
        o_pending = expected_lerps.size();
    end
endmodule
`default_nettype wire

@@ verif/keyframe_linear_interpolator_top_test.sv @@
`default_nettype none
module keyframe_linear_interpolator_top_test;
    import kfli_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NKEYS      = 64;
    localparam int HOLD_OFF   = 250;   // longest query: full scan plus divider and lerp
    localparam int STALL_MAX  = 5000;

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       start = 0;
    logic       busy;
    t_in_item   i_item = '0;
    logic       i_cfg_we = 0;
    logic [6:0] i_cfg_wdata = '0;
    logic       o_strobe;
    t_out_item  o_result;

    int errors, pending, queries, loads;
    int outcome_seen [4];
    int burst_left = 0;
    int stall_cycles = 0;
    int settings_run = 0;
    logic [31:0] key_times [NKEYS];

    keyframe_linear_interpolator_top uut (
        .i_clk, .i_rst_n, .start, .busy, .i_item,
        .i_cfg_we, .i_cfg_wdata, .o_strobe, .o_result
    );

    keyframe_lerp_checker lerp_chk (
        .i_clk, .i_rst_n, .start, .busy, .i_item, .i_cfg_we, .i_cfg_wdata,
        .o_strobe, .o_result, .o_errors(errors), .o_pending(pending),
        .o_queries(queries), .o_loads(loads), .o_outcome_seen(outcome_seen)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || !i_rst_n) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_MAX) begin
            $display("%0t watchdog: no transfer for %0d cycles", $time, STALL_MAX);
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($urandom_range(0, 64)) - 32'd32;
            default: return $urandom();
        endcase
    endfunction

    task automatic send(input t_in_item it);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(0, 15);
        end else begin
            burst_left--;
        end
    endtask

    task automatic load_key(input int slot, input logic [31:0] t);
        t_in_item it;
        it = '0;
        it.command     = CMD_LOAD;
        it.key_slot    = 6'(slot);
        it.key_time    = t;
        it.key_value_x = rand_value();
        it.key_value_y = rand_value();
        it.key_value_z = rand_value();
        it.query_time  = $urandom();
        key_times[slot] = t;
        send(it);
    endtask

    task automatic query(input logic [31:0] q);
        t_in_item it;
        it = '0;
        it.command     = CMD_QUERY;
        it.key_slot    = 6'($urandom());
        it.key_time    = $urandom();
        it.key_value_x = $urandom();
        it.key_value_y = $urandom();
        it.key_value_z = $urandom();
        it.query_time  = q;
        send(it);
    endtask

    // drain all results, then let any trailing load finish before touching config
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (HOLD_OFF) @(posedge i_clk);
    endtask

    task automatic set_keys(input logic [6:0] n);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= n;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        settings_run++;
    endtask

    // fills slots 0..n-1 in time order (mostly), duplicates give zero-length segments
    task automatic fill_table(input int n);
        longint t;
        longint step_max;
        bit     shuffled;
        shuffled = ($urandom_range(0, 9) == 0);
        t = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 32'h0FFF_FFFF);
        step_max = (64'hFFFF_FFFF - t) / n;
        for (int i = 0; i < n; i++) begin
            if (shuffled) begin
                load_key(i, $urandom());
            end else begin
                if (i == n - 1 && $urandom_range(0, 5) == 0) t = 64'hFFFF_FFFF;
                load_key(i, t[31:0]);
                if ($urandom_range(0, 7) != 0) t += $urandom_range(1, int'(step_max));
            end
        end
    endtask

    function automatic logic [31:0] pick_query(input int n);
        int idx;
        idx = $urandom_range(0, n - 1);
        case ($urandom_range(0, 7))
            0: return key_times[idx];
            1: return key_times[idx] - 1;
            2: return key_times[idx] + 1;
            3: return 32'd0;
            4: return 32'hFFFF_FFFF;
            5, 6: begin
                if (idx + 1 < n && key_times[idx + 1] > key_times[idx])
                    return key_times[idx] + $urandom_range(0,
                        int'(key_times[idx + 1] - key_times[idx] - 1) & 32'h7FFF_FFFF);
                return key_times[idx];
            end
            default: return $urandom();
        endcase
    endfunction

    task automatic run_setting(input logic [6:0] n_cfg, input int nq);
        int n;
        n = (n_cfg == 0) ? 1 : (n_cfg > NKEYS) ? NKEYS : n_cfg;
        set_keys(n_cfg);
        fill_table(n);
        for (int i = 0; i < nq; i++) begin
            // occasionally loads into slots above the ones in use, otherwise queries
            if ($urandom_range(0, 9) == 0 && n < NKEYS)
                load_key($urandom_range(n, NKEYS - 1), $urandom());
            else query(pick_query(n));
        end
    endtask

    initial begin
        int items;
        logic [6:0] n_cfg;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: single key at the extremes of the time range
        load_key(0, 32'hFFFF_FFFF);
        query(32'd0);
        query(32'hFFFF_FFFF);
        // zero-length segment, before first, exact hits, past last
        set_keys(7'd3);
        load_key(0, 32'd100);
        load_key(1, 32'd100);
        load_key(2, 32'd300);
        query(32'd10);
        query(32'd100);
        query(32'd200);
        query(32'd299);
        query(32'd300);
        query(32'hFFFF_FFFF);
        // segment spanning the full time range, with randomly drawn key values
        set_keys(7'd2);
        load_key(0, 32'd0);
        load_key(1, 32'hFFFF_FFFF);
        query(32'h8000_0000);
        query(32'hFFFF_FFFE);
        // a key count of zero acts as one key; oversize counts saturate
        set_keys(7'd0);
        query($urandom());
        run_setting(7'd127, 8);
        run_setting(7'd64, 10);
        run_setting(7'd1, 4);

        items = 0;
        while (items < 450) begin
            case ($urandom_range(0, 5))
                0: n_cfg = 7'($urandom_range(2, 4));
                1: n_cfg = 7'($urandom_range(0, 127));
                2: n_cfg = 7'd64;
                default: n_cfg = 7'($urandom_range(2, 16));
            endcase
            run_setting(n_cfg, $urandom_range(15, 40));
            items = loads + queries;
        end

        wait_idle();
        $display("covered %0d loads and %0d queries over %0d key-count settings",
                 loads, queries, settings_run);
        $display("outcomes seen: single %0d, before %0d, interpolated %0d, clamped %0d",
                 outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3]);
        if (errors == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
